FILE: hdl/bounded_array_list_table_assert.svh
// Assertion macros shared by the array list table RTL.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef BOUNDED_ARRAY_LIST_TABLE_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_TABLE_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define BAT_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BAT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BAT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bat_pkg.sv
// Package for the array list table: sizes, operation and status codes,
// controller states and the controller-to-datapath command word. No dependencies.
package bat_pkg;

  // Built depth of the table.
  localparam int MAX_ENTRIES = 16;

  // Widths of the internal index and count.
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Fixed field widths of the ports.
  localparam int MODE_W  = 2;
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 4;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;

  // Width wide enough to compare count, capacity and position.
  localparam int WIDE_A = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WIDE_W = (WIDE_A > POS_W) ? WIDE_A : POS_W;

  // Configuration port.
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Command word from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming word
    logic exec;   // carry out the captured operation
  } dp_cmd_t;

endpackage

FILE: hdl/bat_regs.sv
// Configuration register file of the array list table (APB-style port).
// Depends on bat_pkg.
module bat_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bat_pkg::PADDR_W-1:0] paddr,
  input  logic [bat_pkg::PDATA_W-1:0] pwdata,
  output logic [bat_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [bat_pkg::CAP_W-1:0]   capacity
);
  import bat_pkg::*;

  logic wr_cap;

  // Word address zero holds the capacity limit; the low address bits are ignored.
  assign wr_cap = psel && penable && pwrite && !paddr[2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_cap) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Reads return the capacity limit, zero elsewhere.
  assign prdata = paddr[2] ? '0 : {{(PDATA_W-CAP_W){1'b0}}, capacity};

endmodule

FILE: hdl/bat_ctrl.sv
// Controller of the array list table: accepts a command word, then runs it.
// Depends on bat_pkg.
module bat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output bat_pkg::dp_cmd_t cmd
);
  import bat_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Idle captures a word on start; the execute cycle updates the table.
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/bat_dp.sv
// Datapath of the array list table: operand latch, entry registers, count
// and result registers. Depends on bat_pkg and the assertion macro header.
`include "bounded_array_list_table_assert.svh"

module bat_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  bat_pkg::dp_cmd_t            cmd,
  input  logic [bat_pkg::MODE_W-1:0]  mode,
  input  logic [bat_pkg::POS_W-1:0]   position,
  input  logic [bat_pkg::VALUE_W-1:0] value,
  input  logic [bat_pkg::CAP_W-1:0]   capacity,
  output logic                        done,
  output logic [bat_pkg::STAT_W-1:0]  status,
  output logic [bat_pkg::FOUND_W-1:0] found_index,
  output logic [bat_pkg::COUNT_W-1:0] entry_count
);
  import bat_pkg::*;

  // Captured command word.
  mode_t              op_mode;
  logic [POS_W-1:0]   op_pos;
  logic [VALUE_W-1:0] op_value;

  // Table state.
  logic [VALUE_W-1:0] entries [MAX_ENTRIES];
  logic [CNT_W-1:0]   count, count_next;

  // Result registers.
  status_t            res_status;
  logic [IDX_W-1:0]   res_found;
  logic [CNT_W-1:0]   res_count;

  // Operation decode.
  status_t            status_next;
  logic [IDX_W-1:0]   found_next;
  logic [IDX_W-1:0]   hit_idx;
  logic [WIDE_W-1:0]  cnt_w, cap_w, pos_w;
  logic               is_full, pos_bad, hit;
  logic [IDX_W-1:0]   pos_idx, tail_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= mode_t'(mode);
      op_pos   <= position;
      op_value <= value;
    end
  end

  assign cnt_w    = WIDE_W'(count);
  assign cap_w    = WIDE_W'(capacity);
  assign pos_w    = WIDE_W'(op_pos);
  assign is_full  = (cnt_w >= cap_w) || (count == CNT_W'(MAX_ENTRIES));
  assign pos_bad  = (pos_w >= cnt_w);
  assign pos_idx  = IDX_W'(op_pos);
  assign tail_idx = IDX_W'(count);

  // Status, search result and new count of the captured operation.
  always_comb begin
    status_next = STAT_OK;
    found_next  = '0;
    count_next  = count;
    hit         = 1'b0;
    hit_idx     = '0;
    // Scan from the top so the lowest matching index wins.
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if ((entries[i] == op_value) && (CNT_W'(i) < count)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
    unique case (op_mode)
      MODE_APPEND: begin
        if (is_full) status_next = STAT_FULL;
        else count_next = count + CNT_W'(1);
      end
      MODE_DELETE: begin
        if (pos_bad) status_next = STAT_RANGE;
        else count_next = count - CNT_W'(1);
      end
      MODE_SEARCH: begin
        // Only a successful search reports an index.
        if (hit) found_next = hit_idx;
        else status_next = STAT_NOT_FOUND;
      end
      MODE_UPDATE: begin
        if (pos_bad) status_next = STAT_RANGE;
      end
    endcase
  end

  // Entry writes: append at the tail, update in place, delete shifts down.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        unique case (op_mode)
          MODE_APPEND: begin
            if (!is_full && (tail_idx == IDX_W'(i))) entries[i] <= op_value;
          end
          MODE_DELETE: begin
            if (!pos_bad && (IDX_W'(i) >= pos_idx) && (i < MAX_ENTRIES - 1)) begin
              entries[i] <= entries[(i + 1) % MAX_ENTRIES];
            end
          end
          MODE_UPDATE: begin
            if (!pos_bad && (pos_idx == IDX_W'(i))) entries[i] <= op_value;
          end
          MODE_SEARCH: begin
          end
        endcase
      end
    end
  end

  // Count and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= status_next;
      res_found  <= found_next;
      res_count  <= count_next;
    end
  end

  assign status      = res_status;
  assign found_index = FOUND_W'(res_found);
  assign entry_count = COUNT_W'(res_count);

  `BAT_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(MAX_ENTRIES), "count above depth")
  `BAT_ASSERT_NEXT(a_count_hold, clk, rst, !cmd.exec, $stable(count), "count moved while idle")
  `BAT_ASSERT_IMPL(a_done_after_exec, clk, rst, done, $past(cmd.exec), "result without execute")

endmodule

FILE: hdl/bounded_array_list_table.sv
// Top level of the bounded array list table.
// Depends on bat_pkg, bat_regs, bat_ctrl and bat_dp.

// Each operation has a capture cycle and an execute cycle: the cycle in
// which start is taken with busy low captures the word, and the following
// execute cycle, with busy high, updates the sixteen entry registers and
// the count in one step (parallel compare for search, one-place shift for
// delete). The result appears on status, found_index and entry_count,
// marked by done, in the cycle after the execute cycle, and holds until
// the next execute; the receiver cannot stall it, so it must take it then.
// A new start is accepted in that same cycle, but none while busy is high.
// Entries need no clearing after reset; only entries below the count
// affect a result. The capacity limit sits at byte address 0 of the
// configuration port and should be written only while the table is idle.
module bounded_array_list_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [bat_pkg::MODE_W-1:0]  mode,
  input  logic [bat_pkg::POS_W-1:0]   position,
  input  logic signed [bat_pkg::VALUE_W-1:0] value,
  output logic                        done,
  output logic [bat_pkg::STAT_W-1:0]  status,
  output logic [bat_pkg::FOUND_W-1:0] found_index,
  output logic [bat_pkg::COUNT_W-1:0] entry_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bat_pkg::PADDR_W-1:0] paddr,
  input  logic [bat_pkg::PDATA_W-1:0] pwdata,
  output logic [bat_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import bat_pkg::*;

  dp_cmd_t          cmd;
  logic [CAP_W-1:0] capacity;

  bat_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  bat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  bat_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .position    (position),
    .value       (value),
    .capacity    (capacity),
    .done        (done),
    .status      (status),
    .found_index (found_index),
    .entry_count (entry_count)
  );

endmodule
